FILE: src/desm_pkg.sv
// ----------------------------------------------------------------------------
// desm_pkg
// Shared types, constants and table builders for the dithered ellipse span
// mask: item layouts, register map, Bayer matrix and squared thresholds.
// ----------------------------------------------------------------------------
package desm_pkg;

  localparam int FRAME_WIDTH_DEF      = 640;
  localparam int THRESH_FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH          = 4;

  localparam logic [9:0] CENTER_X_RST = 10'd320;
  localparam logic [9:0] CENTER_Y_RST = 10'd180;
  localparam logic [9:0] RADIUS_X_RST = 10'd205;
  localparam logic [9:0] RADIUS_Y_RST = 10'd122;

  // Configuration register map
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS_X = 2'd2,
    REG_RADIUS_Y = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [9:0] center_x;
    logic [9:0] center_y;
    logic [9:0] radius_x;
    logic [9:0] radius_y;
  } cfg_t;

  typedef struct packed {
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic       row_end;
  } samp_t;

  typedef struct packed {
    logic [9:0]  span_x;
    logic [9:0]  span_y;
    logic [10:0] span_width;
  } span_t;

  // Classified sample handed from the front to the back
  typedef struct packed {
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic       row_end;
    logic       clear;
  } cls_t;

  localparam logic [3:0] BAYER [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  typedef longint unsigned qtab_t [16];

  // Squared threshold (1.31 - 0.02*b)^2 with frac fraction bits, rounded half up
  function automatic qtab_t q_table(int frac);
    qtab_t          tab;
    longint unsigned t;
    for (int b = 0; b < 16; b++) begin
      t = longint'(131 - 2 * b);
      tab[b] = (((t * t) << frac) + 64'd5000) / 64'd10000;
    end
    return tab;
  endfunction

endpackage

FILE: src/desm_stream_if.sv
// ----------------------------------------------------------------------------
// desm_stream_if
// Valid/ready stream channel carrying one item of payload_t per transfer.
// ----------------------------------------------------------------------------
interface desm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/dithered_ellipse_span_mask.sv
// ----------------------------------------------------------------------------
// dithered_ellipse_span_mask
// Dithered elliptic cutout mask over a raster of two-pixel grid samples,
// reported as runs of clear samples.
// ----------------------------------------------------------------------------
// Samples enter on samp in raster order, one per clock when nothing stalls.
// Each is classified clear when its elliptic radius about the configured
// center and radii falls under 1.31 - 0.02*b, b being the 4x4 Bayer entry at
// (pos_y/2)%4, (pos_x/2)%4; the test is done on squares in fixed point with
// THRESH_FRAC_BITS fraction bits, no root taken. Samples at or beyond
// FRAME_WIDTH are never clear. Consecutive clear samples form a run; a run
// ends at the first non-clear sample or at a row_end sample (then at
// pos_x+2), and its span (start, row, width) comes out on span. A row change
// without row_end keeps the run open. Throughput is one sample per clock
// when nothing stalls. A sample passes four front stages (offsets, squares,
// products, sums) with the compare after the last, then the four-entry
// queue and the output register. The output register is the only place a
// span waits, so the back side takes a new sample each cycle while span is
// drained or empty, and the front keeps filling the queue when the back is
// held. Configuration is to be written through cfg_we/cfg_index/cfg_data
// only while the block is idle; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module dithered_ellipse_span_mask import desm_pkg::*; #(
  parameter int FRAME_WIDTH      = FRAME_WIDTH_DEF,
  parameter int THRESH_FRAC_BITS = THRESH_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  desm_stream_if.sink   samp,
  desm_stream_if.source span,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  cfg_t cfg;
  logic fq_valid, fq_ready;
  cls_t fq_data;
  logic qb_valid, qb_ready;
  cls_t qb_data;

  // register file: write strobe, ignore nothing since all four codes map
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= CENTER_X_RST;
      cfg.center_y <= CENTER_Y_RST;
      cfg.radius_x <= RADIUS_X_RST;
      cfg.radius_y <= RADIUS_Y_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_CENTER_X: cfg.center_x <= cfg_data;
        REG_CENTER_Y: cfg.center_y <= cfg_data;
        REG_RADIUS_X: cfg.radius_x <= cfg_data;
        REG_RADIUS_Y: cfg.radius_y <= cfg_data;
        default:      cfg <= cfg;
      endcase
    end
  end

  // front: classify each sample
  desm_front #(
    .FRAME_WIDTH      (FRAME_WIDTH),
    .THRESH_FRAC_BITS (THRESH_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (samp.valid),
    .in_ready  (samp.ready),
    .in_data   (samp.payload),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_data  (fq_data)
  );

  // decouple classification from run tracking
  desm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // back: track runs, hold spans for the consumer
  desm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_data   (qb_data),
    .out_valid (span.valid),
    .out_ready (span.ready),
    .out_data  (span.payload)
  );

endmodule

FILE: src/desm_front.sv
// ----------------------------------------------------------------------------
// desm_front
// Four-stage classifier: decides whether each sample lies inside the
// dithered ellipse by comparing squared, radius-weighted distance against
// a squared fixed-point threshold.
// ----------------------------------------------------------------------------
module desm_front import desm_pkg::*; #(
  parameter int FRAME_WIDTH      = FRAME_WIDTH_DEF,
  parameter int THRESH_FRAC_BITS = THRESH_FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  samp_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output cls_t  out_data
);

  localparam int    QW   = THRESH_FRAC_BITS + 1;
  localparam int    PW   = QW + 20;
  localparam int    CW   = THRESH_FRAC_BITS + 42;
  localparam qtab_t QTAB = q_table(THRESH_FRAC_BITS);

  // radius products, refreshed every cycle from the registers
  logic [19:0] rx2, ry2;
  logic [39:0] rxy2;

  logic        adv;
  logic        v1, v2, v3, v4;
  samp_t       s1_item, s2_item, s3_item, s4_item;
  logic        s1_ok, s2_ok, s3_ok, s4_ok;
  logic [9:0]  s1_dx, s1_dy;
  logic [3:0]  s1_b;
  logic [19:0] s2_dx2, s2_dy2;
  logic [QW-1:0] s2_q;
  logic [39:0] s3_la, s3_lb;
  logic [PW-1:0] s3_ph, s3_pl;
  logic [40:0] s4_lsum;
  logic [CW-1:0] s4_rhs;
  logic [CW-1:0] lhs_q;

  always_ff @(posedge clk) begin
    rx2  <= 20'(cfg.radius_x) * 20'(cfg.radius_x);
    ry2  <= 20'(cfg.radius_y) * 20'(cfg.radius_y);
    rxy2 <= 40'(rx2) * 40'(ry2);
  end

  // stall every stage together when the last one cannot hand off
  assign adv      = !v4 || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // absolute offsets, frame check, dither entry
      s1_item <= in_data;
      s1_ok   <= {1'b0, in_data.pos_x} < 11'(FRAME_WIDTH);
      s1_dx   <= (in_data.pos_x >= cfg.center_x) ? in_data.pos_x - cfg.center_x
                                                 : cfg.center_x - in_data.pos_x;
      s1_dy   <= (in_data.pos_y >= cfg.center_y) ? in_data.pos_y - cfg.center_y
                                                 : cfg.center_y - in_data.pos_y;
      s1_b    <= BAYER[in_data.pos_y[2:1]][in_data.pos_x[2:1]];
      // squares and threshold lookup
      s2_item <= s1_item;
      s2_ok   <= s1_ok;
      s2_dx2  <= 20'(s1_dx) * 20'(s1_dx);
      s2_dy2  <= 20'(s1_dy) * 20'(s1_dy);
      s2_q    <= QW'(QTAB[s1_b]);
      // weighted terms, threshold times rx^2*ry^2 in two halves
      s3_item <= s2_item;
      s3_ok   <= s2_ok;
      s3_la   <= 40'(s2_dx2) * 40'(ry2);
      s3_lb   <= 40'(s2_dy2) * 40'(rx2);
      s3_ph   <= PW'(s2_q) * PW'(rxy2[39:20]);
      s3_pl   <= PW'(s2_q) * PW'(rxy2[19:0]);
      // sums
      s4_item <= s3_item;
      s4_ok   <= s3_ok;
      s4_lsum <= 41'(s3_la) + 41'(s3_lb);
      s4_rhs  <= CW'({s3_ph, 20'd0}) + CW'(s3_pl);
    end
  end

  assign lhs_q = CW'(s4_lsum) << THRESH_FRAC_BITS;

  assign out_valid        = v4;
  assign out_data.pos_x   = s4_item.pos_x;
  assign out_data.pos_y   = s4_item.pos_y;
  assign out_data.row_end = s4_item.row_end;
  assign out_data.clear   = s4_ok && (lhs_q < s4_rhs);

endmodule

FILE: src/desm_queue.sv
// ----------------------------------------------------------------------------
// desm_queue
// Small show-ahead FIFO of classified samples between front and back.
// ----------------------------------------------------------------------------
module desm_queue import desm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cls_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cls_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_t             entries [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (push && pop) |=> count == $past(count))
    else $error("queue fill moved on simultaneous push and pop");

endmodule

FILE: src/desm_back.sv
// ----------------------------------------------------------------------------
// desm_back
// Run tracker: turns classified samples into clear spans and holds each
// span in an output register until it is taken.
// ----------------------------------------------------------------------------
module desm_back import desm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cls_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output span_t out_data
);

  logic        run_open, run_open_next;
  logic [9:0]  run_start, run_start_next;
  logic        emit;
  logic [10:0] end_x;
  logic        take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    run_open_next  = run_open;
    run_start_next = run_start;
    emit           = 1'b0;
    end_x          = {1'b0, in_data.pos_x};
    if (in_data.clear && !run_open) begin
      run_open_next  = 1'b1;
      run_start_next = in_data.pos_x;
    end else if (!in_data.clear && run_open) begin
      emit          = 1'b1;
      run_open_next = 1'b0;
    end
    if (!emit && in_data.row_end && run_open_next) begin
      emit          = 1'b1;
      end_x         = {1'b0, in_data.pos_x} + 11'd2;
      run_open_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open  <= 1'b0;
      run_start <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        run_open  <= run_open_next;
        run_start <= run_start_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data.span_x     <= run_start_next;
      out_data.span_y     <= in_data.pos_y;
      out_data.span_width <= end_x - {1'b0, run_start_next};
    end
  end

  a_emit_closes: assert property (@(posedge clk) disable iff (rst)
    (take && emit) |=> !run_open)
    else $error("run still open after span emitted");

  a_clear_opens: assert property (@(posedge clk) disable iff (rst)
    (take && in_data.clear && !run_open && !in_data.row_end) |=> run_open)
    else $error("clear sample did not open a run");

endmodule

FILE: tb/dithered_ellipse_span_mask_test.sv
// ----------------------------------------------------------------------------
// dithered_ellipse_span_mask_test
// Self-checking bench for the dithered ellipse span mask. A short table of
// directed samples and register writes comes first, then random raster scans
// and noise under random ellipse settings. Each accepted sample runs through a
// local span predictor, and every span that leaves the block is compared field
// by field with the oldest pending span.
// ----------------------------------------------------------------------------
module dithered_ellipse_span_mask_test;
  import desm_pkg::*;

  localparam int FRAME_W    = 640;
  localparam int FRAC_BITS  = 16;
  localparam int RAND_ITEMS = 900;
  localparam int TAIL_ITEMS = 120;
  localparam int SETTLE     = 12;      // wait for samples still in the pipe
  localparam int LIMIT      = 200000;

  // Bayer matrix, indexed [row][column]
  localparam logic [3:0] DITHER [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  // One row of the directed table: a register write or a sample. A sample
  // marked fixed carries its span (or the lack of one) typed in by hand.
  typedef struct {
    bit         is_cfg;
    reg_index_t idx;
    logic [9:0] data;
    samp_t      s;
    bit         fixed;
    bit         hit;
    span_t      sp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  desm_stream_if #(.payload_t(samp_t)) samp_ch ();
  desm_stream_if #(.payload_t(span_t)) span_ch ();

  dithered_ellipse_span_mask #(
    .FRAME_WIDTH      (FRAME_W),
    .THRESH_FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .samp      (samp_ch),
    .span      (span_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the block's registers and run state
  logic [9:0] m_center_x, m_center_y, m_radius_x, m_radius_y;
  bit         m_run_open;
  logic [9:0] m_run_start;

  span_t pending_spans [$];

  // Side tags that travel with the sample on the wire
  bit    cur_fixed;
  bit    cur_hit;
  span_t cur_span;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int sent_items     = 0;
  int stall_left     = 0;
  bit no_idle        = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Span predictor
  // --------------------------------------------------------------------------

  // T^2 = ((131 - 2b)/100)^2 in fixed point, rounded half up
  function automatic logic [63:0] thresh_q(logic [3:0] b);
    logic [63:0] t;
    t = 64'(131 - 2 * int'(b));
    return (((t * t) << FRAC_BITS) + 64'd5000) / 64'd10000;
  endfunction

  // Weighted squared distance against the dithered squared threshold; all
  // products stay exact at 128 bits.
  function automatic bit sample_is_clear(logic [9:0] x, logic [9:0] y);
    logic [127:0] dx, dy, rx2, ry2, lhs, rhs;
    if (int'(x) >= FRAME_W || m_radius_x == 10'd0 || m_radius_y == 10'd0) return 1'b0;
    dx  = (x >= m_center_x) ? 128'(x - m_center_x) : 128'(m_center_x - x);
    dy  = (y >= m_center_y) ? 128'(y - m_center_y) : 128'(m_center_y - y);
    rx2 = 128'(m_radius_x) * 128'(m_radius_x);
    ry2 = 128'(m_radius_y) * 128'(m_radius_y);
    lhs = (dx * dx * ry2 + dy * dy * rx2) << FRAC_BITS;
    rhs = 128'(thresh_q(DITHER[y[2:1]][x[2:1]])) * rx2 * ry2;
    return lhs < rhs;
  endfunction

  // Advance the run state by one sample; return 1 when a span closes
  function automatic bit mask_step(samp_t s, output span_t sp);
    bit clr;
    clr = sample_is_clear(s.pos_x, s.pos_y);
    sp  = '0;
    if (clr && !m_run_open) begin
      m_run_open  = 1'b1;
      m_run_start = s.pos_x;
    end else if (!clr && m_run_open) begin
      sp.span_x     = m_run_start;
      sp.span_y     = s.pos_y;
      sp.span_width = 11'({1'b0, s.pos_x} - {1'b0, m_run_start});
      m_run_open    = 1'b0;
      return 1'b1;
    end
    if (s.row_end && m_run_open) begin
      sp.span_x     = m_run_start;
      sp.span_y     = s.pos_y;
      sp.span_width = 11'({1'b0, s.pos_x} + 11'd2 - {1'b0, m_run_start});
      m_run_open    = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Checking: predict on accepted samples, compare on accepted spans. Both
  // sides are sampled at the rising edge; all drives change on the falling.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_b
    span_t sp;
    span_t want;
    span_t got;
    bit    hit;
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst) begin
      m_center_x  = CENTER_X_RST;
      m_center_y  = CENTER_Y_RST;
      m_radius_x  = RADIUS_X_RST;
      m_radius_y  = RADIUS_Y_RST;
      m_run_open  = 1'b0;
      m_run_start = 10'd0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_CENTER_X: m_center_x = cfg_data;
          REG_CENTER_Y: m_center_y = cfg_data;
          REG_RADIUS_X: m_radius_x = cfg_data;
          REG_RADIUS_Y: m_radius_y = cfg_data;
          default: ;
        endcase
      end
      // Predict first: a span never leaves in the cycle its sample enters
      if (samp_ch.valid && samp_ch.ready) begin
        hit = mask_step(samp_ch.payload, sp);
        if (cur_fixed) begin
          if (cur_hit) pending_spans.insert(pending_spans.size(), cur_span);
        end else if (hit) begin
          pending_spans.insert(pending_spans.size(), sp);
        end
      end
      if (span_ch.valid && span_ch.ready) begin
        got = span_ch.payload;
        if (pending_spans.size() == 0) begin
          report_mismatch($sformatf("unexpected span x=%0d y=%0d w=%0d",
                                    got.span_x, got.span_y, got.span_width));
        end else begin
          want = pending_spans.pop_front();
          if (got.span_x != want.span_x)
            report_mismatch($sformatf("span_x %0d, want %0d", got.span_x, want.span_x));
          if (got.span_y != want.span_y)
            report_mismatch($sformatf("span_y %0d, want %0d", got.span_y, want.span_y));
          if (got.span_width != want.span_width)
            report_mismatch($sformatf("span_width %0d, want %0d",
                                      got.span_width, want.span_width));
        end
      end
    end
  end

  // Receiver: stall in bursts at random, never in quiet stretches
  always @(negedge clk) begin
    if (no_idle) begin
      span_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      span_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      span_ch.ready <= 1'b0;
    end else begin
      span_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task is entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one sample, maybe after a short gap, and hold it until accepted
  task automatic push_sample(samp_t s, bit fixed, bit hit, span_t sp);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      samp_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    samp_ch.valid   <= 1'b1;
    samp_ch.payload <= s;
    cur_fixed       <= fixed;
    cur_hit         <= hit;
    cur_span        <= sp;
    @(posedge clk);
    while (!samp_ch.ready) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every pending span has come out
  task automatic hold_until_drained();
    samp_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_spans.size() != 0) @(negedge clk);
  endtask

  // Write one register with the block idle; samples that closed no span may
  // still be in the pipe, so let the latency pass as well
  task automatic write_reg(reg_index_t idx, logic [9:0] data);
    hold_until_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [9:0] clamp_even(int v);
    if (v < 0) v = 0;
    if (v > 1022) v = 1022;
    return 10'(v & ~1);
  endfunction

  function automatic dir_row_t row_s(int x, int y, bit e);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = REG_CENTER_X;
    r.data   = 10'd0;
    r.s      = '{pos_x: 10'(x), pos_y: 10'(y), row_end: e};
    r.fixed  = 1'b0;
    r.hit    = 1'b0;
    r.sp     = '0;
    return r;
  endfunction

  function automatic dir_row_t row_t(int x, int y, bit e, bit hit,
                                     int sx = 0, int sy = 0, int sw = 0);
    dir_row_t r;
    r       = row_s(x, y, e);
    r.fixed = 1'b1;
    r.hit   = hit;
    r.sp    = '{span_x: 10'(sx), span_y: 10'(sy), span_width: 11'(sw)};
    return r;
  endfunction

  function automatic dir_row_t row_c(reg_index_t idx, int data);
    dir_row_t r;
    r        = row_s(0, 0, 1'b0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = 10'(data);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stim_b
    dir_row_t dir_rows [$];
    span_t    no_span;
    int cx, cy, rx, ry;
    int y0, x0, len, nrows, n;
    int phase_goal, rand_goal;
    logic [9:0] xs, ys, xk;

    samp_ch.valid   = 1'b0;
    samp_ch.payload = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_CENTER_X;
    cfg_data        = 10'd0;
    cur_fixed       = 1'b0;
    cur_hit         = 1'b0;
    cur_span        = '0;
    no_span         = '0;

    // Reset config: center (320,180), radii 205 x 122
    dir_rows = '{
      row_t(0, 0, 0, 0),                        // far outside, nothing open
      row_t(320, 180, 1, 1, 320, 180, 2),       // center, closed by row end
      row_t(322, 180, 0, 0),                    // open a run
      row_t(324, 180, 0, 0),                    // extend it
      row_t(1022, 180, 0, 1, 322, 180, 700),    // beyond the frame closes it
      row_t(1023, 1023, 1, 0),                  // all ones, no run open
      row_s(321, 181, 0),                       // odd coordinates
      row_s(323, 183, 0),                       // row change, no row end
      row_s(318, 184, 0),                       // going backwards
      row_s(0, 184, 1),                         // close with a wrapped width
      row_c(REG_CENTER_X, 639),
      row_c(REG_CENTER_Y, 0),
      row_t(638, 0, 0, 0),                      // last column inside the frame
      row_t(640, 0, 1, 1, 638, 0, 2),           // first column past the frame
      row_c(REG_RADIUS_X, 0),
      row_t(638, 0, 1, 0),                      // zero radius: never clear
      row_c(REG_RADIUS_X, 1023),
      row_c(REG_RADIUS_Y, 1023),
      row_c(REG_CENTER_X, 0),
      row_c(REG_CENTER_Y, 1023),
      row_t(0, 1022, 0, 0),
      row_t(1022, 1022, 1, 1, 0, 1022, 1022),
      row_c(REG_RADIUS_X, 1),
      row_c(REG_RADIUS_Y, 1),
      row_t(0, 1023, 1, 1, 0, 1023, 2),         // unit radii, exact center
      row_s(2, 1022, 1)
    };

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        push_sample(dir_rows[i].s, dir_rows[i].fixed, dir_rows[i].hit, dir_rows[i].sp);
      end
    end

    // Random phases: new ellipse, then raster windows over its edge mixed
    // with noise
    rand_goal = sent_items + RAND_ITEMS;
    while (sent_items < rand_goal) begin
      case ($urandom_range(0, 9))
        0:       cx = 0;
        1:       cx = 1023;
        default: cx = $urandom_range(0, 700);
      endcase
      case ($urandom_range(0, 9))
        0:       cy = 0;
        1:       cy = 1023;
        default: cy = $urandom_range(0, 1023);
      endcase
      case ($urandom_range(0, 11))
        0:       rx = 0;
        1:       rx = 1;
        2:       rx = 1023;
        3, 4:    rx = $urandom_range(1, 1023);
        default: rx = $urandom_range(2, 160);
      endcase
      case ($urandom_range(0, 11))
        0:       ry = 0;
        1:       ry = 1;
        2:       ry = 1023;
        3, 4:    ry = $urandom_range(1, 1023);
        default: ry = $urandom_range(2, 160);
      endcase
      write_reg(REG_CENTER_X, 10'(cx));
      write_reg(REG_CENTER_Y, 10'(cy));
      write_reg(REG_RADIUS_X, 10'(rx));
      write_reg(REG_RADIUS_Y, 10'(ry));

      // Quiet phases now and then, and only quiet ones near the end
      no_idle    = (sent_items >= rand_goal - TAIL_ITEMS) || ($urandom_range(0, 3) == 0);
      phase_goal = sent_items + $urandom_range(40, 120);
      while (sent_items < phase_goal) begin
        if (sent_items >= rand_goal - TAIL_ITEMS) no_idle = 1'b1;
        if ($urandom_range(0, 4) != 0) begin
          // Raster window: a few rows crossing the ellipse edge
          nrows = $urandom_range(1, 4);
          len   = $urandom_range(4, 40);
          y0    = cy + int'($urandom_range(0, 2 * ry + 8)) - ry - 4;
          x0    = cx + int'($urandom_range(0, 2 * rx + 16)) - rx - 8 - len;
          xs    = clamp_even(x0);
          n     = (1022 - int'(xs)) / 2 + 1;
          if (n > len) n = len;
          for (int r = 0; r < nrows; r++) begin
            ys = clamp_even(y0 + 2 * r);
            for (int k = 0; k < n; k++) begin
              xk = xs + 10'(2 * k);
              // Leave the row end off now and then so a run spans rows
              push_sample('{pos_x: xk, pos_y: ys,
                            row_end: (k == n - 1) && ($urandom_range(0, 7) != 0)},
                          1'b0, 1'b0, no_span);
            end
          end
        end else begin
          // Noise: any coordinates, odd ones too, any row end
          repeat ($urandom_range(1, 8)) begin
            push_sample('{pos_x: 10'($urandom_range(0, 1023)),
                          pos_y: 10'($urandom_range(0, 1023)),
                          row_end: 1'($urandom_range(0, 1))},
                        1'b0, 1'b0, no_span);
          end
        end
        if ($urandom_range(0, 9) == 0) hold_until_drained();
      end
    end

    // Drain: wait out every pending span, then the pipe latency
    no_idle = 1'b1;
    hold_until_drained();
    repeat (2 * SETTLE) @(negedge clk);
    if (mismatch_count == 0 && pending_spans.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
